[src/lrupr_pkg.sv]
`default_nettype none

package lrupr_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 4;
    localparam int FAULT_W       = 32;

    localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

    // per-beat control broadcast to every cell of the recency chain
    typedef struct packed {
        logic upd;
        logic hit;
    } lrupr_ctrl_t;

endpackage

`default_nettype wire

[src/lrupr_cell.sv]
`default_nettype none

module lrupr_cell #(
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire lrupr_pkg::lrupr_ctrl_t ctrl,
    input  wire  [PAGE_BITS-1:0]     lookup_page,
    input  wire                      miss_stop,
    input  wire                      carry_in,
    input  wire  [PAGE_BITS-1:0]     left_page,
    input  wire                      left_valid,
    output logic [PAGE_BITS-1:0]     page,
    output logic                     valid,
    output logic                     match,
    output logic                     stop,
    output logic                     carry_out
);

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 shift;

    assign match     = valid_reg && (page_reg == lookup_page);
    // on a hit the chain ends at the matching cell, on a miss at the slot chosen by the top
    assign stop      = ctrl.hit ? match : miss_stop;
    assign shift     = ctrl.upd && carry_in;
    assign carry_out = carry_in && !stop;

    assign page_next  = shift ? left_page : page_reg;
    assign valid_next = shift ? left_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign page  = page_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

[src/lru_page_replacement_core.sv]
`default_nettype none

// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_ready, page_number           | in
// out     | out_valid, out_ready, hit, evicted,       | out
//         | evicted_page, fault_count                 |
// cfg     | cfg_valid, cfg_ready, cfg_data            | in
//
// one beat per cycle while the out side drains: lookup, reorder and result
// register all settle in the cycle the beat is taken; the compare-to-stop carry
// ripple through the cell chain sets the cycle time.
// the output register frees in the same cycle it is drained, so a stalled
// out side holds in_ready low only while a result waits.
// reset clears valid bits, resident count and fault count and sets capacity to 8.
// cfg_ready is always high.

module lru_page_replacement_core #(
    parameter int ENTRIES   = lrupr_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [PAGE_BITS-1:0]            page_number,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic                            hit,
    output logic                            evicted,
    output logic [PAGE_BITS-1:0]            evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]   fault_count,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [lrupr_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;

    logic [lrupr_pkg::CFG_W-1:0]   cap_reg;
    logic [lrupr_pkg::CFG_W-1:0]   cap_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [lrupr_pkg::FAULT_W-1:0] fault_reg;
    logic [lrupr_pkg::FAULT_W-1:0] fault_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          hit_reg;
    logic                          hit_next;
    logic                          evicted_reg;
    logic                          evicted_next;
    logic [PAGE_BITS-1:0]          evicted_page_reg;
    logic [PAGE_BITS-1:0]          evicted_page_next;

    logic                          accept;
    logic                          hit_any;
    logic                          full;
    logic [CMP_W-1:0]              eff_cap;
    logic [CMP_W-1:0]              cap_ext;
    logic [CNT_W-1:0]              stop_cnt;
    logic [PAGE_BITS-1:0]          victim_page;
    lrupr_pkg::lrupr_ctrl_t        ctrl;

    logic [PAGE_BITS-1:0]          cell_page [ENTRIES];
    logic [ENTRIES-1:0]            valid_vec;
    logic [ENTRIES-1:0]            match_vec;
    logic [ENTRIES-1:0]            stop_vec;
    logic [ENTRIES-1:0]            miss_stop_vec;
    logic [ENTRIES:0]              carry;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign hit_any = |match_vec;

    // clamp capacity to 1..ENTRIES
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        eff_cap = cap_ext;
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
    end

    assign full = CMP_W'(count_reg) >= eff_cap;

    // a full miss drops the last valid cell, otherwise the chain grows by one
    assign stop_cnt = full ? (count_reg - CNT_W'(1)) : count_reg;

    assign ctrl.upd = accept;
    assign ctrl.hit = hit_any;

    assign carry[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic [PAGE_BITS-1:0] left_page;
            logic                 left_valid;

            if (gi == 0)
            begin : g_head
                assign left_page  = page_number;
                assign left_valid = 1'b1;
            end
            else
            begin : g_body
                assign left_page  = cell_page[gi-1];
                assign left_valid = valid_vec[gi-1];
            end

            assign miss_stop_vec[gi] = (stop_cnt == CNT_W'(gi));

            lrupr_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .lookup_page (page_number),
                .miss_stop   (miss_stop_vec[gi]),
                .carry_in    (carry[gi]),
                .left_page   (left_page),
                .left_valid  (left_valid),
                .page        (cell_page[gi]),
                .valid       (valid_vec[gi]),
                .match       (match_vec[gi]),
                .stop        (stop_vec[gi]),
                .carry_out   (carry[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        victim_page = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (stop_vec[i])
            begin
                victim_page = victim_page | cell_page[i];
            end
        end
    end

    always_comb
    begin
        cap_next          = cap_reg;
        count_next        = count_reg;
        fault_next        = fault_reg;
        out_valid_next    = out_valid_reg;
        hit_next          = hit_reg;
        evicted_next      = evicted_reg;
        evicted_page_next = evicted_page_reg;

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next    = 1'b1;
            hit_next          = hit_any;
            evicted_next      = !hit_any && full;
            evicted_page_next = (!hit_any && full) ? victim_page : '0;
            if (!hit_any)
            begin
                if (fault_reg != '1)
                begin
                    fault_next = fault_reg + lrupr_pkg::FAULT_W'(1);
                end
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lrupr_pkg::CAP_RESET;
            count_reg     <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg          <= hit_next;
        evicted_reg      <= evicted_next;
        evicted_page_reg <= evicted_page_next;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;
    // the counter only moves on an accepted beat, which needs the result drained
    assign fault_count  = fault_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(ENTRIES))
        else $error("resident count above entry count");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("resident count disagrees with valid cells");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + ENTRIES'(1))) == '0)
        else $error("valid cells not packed toward the head");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("page resident in more than one cell");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !hit_any |=> fault_reg != '0)
        else $error("fault left counter at zero");
`endif

endmodule

`default_nettype wire

[verif/tb_lru_page_replacement_core.sv]
`default_nettype none

module tb_lru_page_replacement_core;

    localparam int PW         = lrupr_pkg::PAGE_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;

    class page_lru_scoreboard;

        typedef struct {
            logic           hit;
            logic           evicted;
            logic [PW-1:0]  evicted_page;
            logic [31:0]    fault_count;
        } page_outcome_t;

        logic [PW-1:0]              slot_pg   [lrupr_pkg::ENTRIES_DEF];
        bit                         slot_vld  [lrupr_pkg::ENTRIES_DEF];
        int                         slot_rank [lrupr_pkg::ENTRIES_DEF];
        logic [31:0]                faults;
        logic [lrupr_pkg::CFG_W-1:0] capacity;
        page_outcome_t              expected_outcomes [$];
        int                         mismatches;

        function new();
            foreach (slot_vld[i])
            begin
                slot_pg[i]   = '0;
                slot_vld[i]  = 1'b0;
                slot_rank[i] = 0;
            end
            faults     = '0;
            capacity   = lrupr_pkg::CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [lrupr_pkg::CFG_W-1:0] v);
            capacity = v;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // work out residency after one reference and queue the outcome
        function void note_reference(logic [PW-1:0] p);
            int found;
            int count;
            int target;
            int eff;
            int oldest;
            int age;
            page_outcome_t r;
            found  = -1;
            count  = 0;
            target = -1;
            oldest = 0;
            r.hit = 1'b0;
            r.evicted = 1'b0;
            r.evicted_page = '0;
            foreach (slot_vld[i])
            begin
                if (slot_vld[i])
                begin
                    count++;
                    if (found < 0 && slot_pg[i] == p)
                        found = i;
                end
            end
            if (found >= 0)
            begin
                r.hit = 1'b1;
                age = slot_rank[found];
                foreach (slot_vld[i])
                    if (slot_vld[i] && slot_rank[i] < age)
                        slot_rank[i]++;
                slot_rank[found] = 0;
            end
            else
            begin
                if (faults != 32'hFFFF_FFFF)
                    faults++;
                eff = int'(capacity);
                if (eff == 0)
                    eff = 1;
                if (eff > lrupr_pkg::ENTRIES_DEF)
                    eff = lrupr_pkg::ENTRIES_DEF;
                if (count >= eff)
                begin
                    foreach (slot_vld[i])
                    begin
                        if (slot_vld[i] && (target < 0 || slot_rank[i] > oldest))
                        begin
                            target = i;
                            oldest = slot_rank[i];
                        end
                    end
                    r.evicted      = 1'b1;
                    r.evicted_page = slot_pg[target];
                    slot_vld[target] = 1'b0;
                end
                else
                begin
                    foreach (slot_vld[i])
                        if (!slot_vld[i] && target < 0)
                            target = i;
                end
                foreach (slot_vld[i])
                    if (slot_vld[i])
                        slot_rank[i]++;
                if (target >= 0)
                begin
                    slot_pg[target]   = p;
                    slot_vld[target]  = 1'b1;
                    slot_rank[target] = 0;
                end
            end
            r.fault_count = faults;
            expected_outcomes.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic h, logic e, logic [PW-1:0] ep, logic [31:0] fc);
            page_outcome_t x;
            if (expected_outcomes.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            x = expected_outcomes.pop_front();
            if (h !== x.hit)
                report_mismatch($sformatf("hit got %b exp %b", h, x.hit));
            if (e !== x.evicted)
                report_mismatch($sformatf("evicted got %b exp %b", e, x.evicted));
            if (ep !== x.evicted_page)
                report_mismatch($sformatf("evicted_page got %h exp %h", ep, x.evicted_page));
            if (fc !== x.fault_count)
                report_mismatch($sformatf("fault_count got %h exp %h", fc, x.fault_count));
        endtask

    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [PW-1:0]                  page_number;
    logic                           out_valid;
    logic                           out_ready;
    logic                           hit;
    logic                           evicted;
    logic [PW-1:0]                  evicted_page;
    logic [lrupr_pkg::FAULT_W-1:0]  fault_count;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lrupr_pkg::CFG_W-1:0]    cfg_data;

    page_lru_scoreboard sb = new();
    int stall_mode;
    int idle_cycles;

    lru_page_replacement_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page_number  (page_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .fault_count  (fault_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // results are checked before the new reference is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(hit, evicted, evicted_page, fault_count);
            if (in_valid && in_ready)
                sb.note_reference(page_number);
            if (cfg_valid && cfg_ready)
                sb.set_capacity(cfg_data);
        end
    end

    // receiver stalls: none, short and rare, or long and frequent
    initial
    begin : out_stalls
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (stall_mode != 0 &&
                     $urandom_range(0, 99) < (stall_mode == 1 ? 15 : 40))
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, stall_mode == 1 ? 3 : 19);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_lru_page_replacement_core failed");
        $finish;
    end

    task automatic put_page(input logic [PW-1:0] p);
        @(negedge clk);
        in_valid    <= 1'b1;
        page_number <= p;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic hold_input(input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // only issued with the input side quiet and every result drained
    task automatic write_capacity(input logic [lrupr_pkg::CFG_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_directed(input logic [PW-1:0] p);
        put_page(p);
        hold_input($urandom_range(0, 2));
    endtask

    initial
    begin : stimulus
        logic [lrupr_pkg::CFG_W-1:0] cap_plan [17];
        logic [PW-1:0]               pool [$];
        int                          eff;
        int                          sent;
        int                          burst;
        bit                          no_gaps;
        logic [PW-1:0]               p;

        cap_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd12, 4'd5, 4'd2, 4'd9,
                     4'd4, 4'd6, 4'd7, 4'd10, 4'd11, 4'd13, 4'd14, 4'd8};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        page_number = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        stall_mode  = 1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill at reset capacity, reorder on a hit, then evict the oldest
        send_directed(16'h0000);
        send_directed(16'hFFFF);
        send_directed(16'h0000);
        for (int k = 1; k <= 6; k++)
            send_directed(PW'(k));
        send_directed(16'h8000);
        send_directed(16'h0001);
        send_directed(16'h7FFF);
        hold_input(1);

        // capacity dropped below the resident count
        write_capacity(4'd2);
        send_directed(16'h1234);
        send_directed(16'h1234);
        send_directed(16'hABCD);
        send_directed(16'hFFFF);
        hold_input(1);

        // zero capacity acts as one slot
        write_capacity(4'd0);
        send_directed(16'h0000);
        send_directed(16'h0000);
        send_directed(16'h0001);
        hold_input(1);

        // capacity above the slot count clamps to all slots
        write_capacity(4'd15);
        send_directed(16'h5555);
        send_directed(16'hAAAA);
        hold_input(1);

        for (int ph = 0; ph < 17; ph++)
        begin
            write_capacity(cap_plan[ph]);
            stall_mode = ph % 3;
            no_gaps    = (ph % 4 == 1);
            eff = int'(cap_plan[ph]);
            if (eff == 0)
                eff = 1;
            if (eff > lrupr_pkg::ENTRIES_DEF)
                eff = lrupr_pkg::ENTRIES_DEF;
            // a working set from the capacity up to a little larger gives hits and evictions
            pool.delete();
            repeat (eff + $urandom_range(0, 3))
                pool.push_back(PW'($urandom));
            sent = 0;
            while (sent < 45)
            begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst && sent < 45; b++)
                begin
                    case ($urandom_range(0, 19))
                        0:       p = '0;
                        1:       p = '1;
                        2, 3:    p = PW'($urandom);
                        default: p = pool[$urandom_range(0, pool.size() - 1)];
                    endcase
                    put_page(p);
                    sent++;
                end
                hold_input(no_gaps ? 0 : $urandom_range(0, 10));
            end
            hold_input(1);
        end

        stall_mode = 1;
        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_lru_page_replacement_core passed");
        else
            $display("tb_lru_page_replacement_core failed");
        $finish;
    end

endmodule

`default_nettype wire
